/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the block bitmap allocator.
// Used by bba_byte_match and block_bitmap_allocator; no dependencies.

package bba_pkg;

   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   localparam logic [12:0] BITS_IN_USE_RESET = 13'd4096;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] position;
      logic        status;
   } req_type;

   typedef struct packed {
      logic        error;
      logic [11:0] found_index;
      logic        bit_value;
      logic [7:0]  byte_value;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] bit_idx;
      logic       last;
   } match_type;

endpackage

/* rtl/bba_byte_match.sv */
`timescale 1ns / 1ps
// Checks one bitmap byte during a search: finds the lowest wanted bit that
// lies at or above the start and below the limit. Depends on bba_pkg.

module bba_byte_match (
   input  logic [7:0]          rd_byte,
   input  logic [9:0]          byte_idx,
   input  logic                status,
   input  logic                first,
   input  logic [2:0]          start_bit,
   input  logic [12:0]         limit,
   output bba_pkg::match_type  match
);

   logic [7:0]  cand;
   logic [9:0]  limit_byte;
   logic [2:0]  limit_bit;
   logic [12:0] limit_m1;
   logic [9:0]  byte_ext;

   always_comb begin
      limit_byte = limit[12:3];
      limit_bit  = limit[2:0];
      limit_m1   = limit - 13'd1;
      byte_ext   = byte_idx;
      cand       = status ? rd_byte : ~rd_byte;
      for (int k = 0; k < 8; k++) begin
         // drop bits below the search start and at or past the limit
         if (first && (3'(k) < start_bit)) begin
            cand[k] = 1'b0;
         end
         if (!((byte_ext < limit_byte) ||
               ((byte_ext == limit_byte) && (3'(k) < limit_bit)))) begin
            cand[k] = 1'b0;
         end
      end
      match.hit     = |cand;
      match.bit_idx = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (cand[k]) begin
            match.bit_idx = 3'(k);
         end
      end
      match.last = (byte_ext >= limit_m1[12:3]);
   end

endmodule

/* rtl/block_bitmap_allocator.sv */
`timescale 1ns / 1ps
// Block-usage bitmap with first-fit search, held in a byte memory (registered read).
// Read/write: the byte is read, then ST_ACCESS registers the result; no new request is taken until then.
// Search: ST_SCAN reads the bytes from the start position toward the limit, one per cycle and up to 512
// at the default, until a hit; no new request is taken until the result is issued. A result waiting on
// rsp_ready stalls the next request in ST_ACCESS or ST_SCAN. After reset a clearing pass writes zero to
// every one of the (MAX_BITS+7)/8 bytes (512 at the default), with req_ready low; csr writes are taken throughout.

module block_bitmap_allocator #(
   parameter int MAX_BITS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [12:0]      csr_data
);

   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam logic [12:0] MAX_LIMIT = (MAX_BITS > 8191) ? 13'h1FFF : 13'(MAX_BITS);

   logic [7:0] mem [STORE_BYTES];

   bba_pkg::state_type state_ff, state_in;
   bba_pkg::req_type   req_ff, req_in;
   bba_pkg::rsp_type   rsp_ff, rsp_in;
   bba_pkg::match_type match;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [12:0]        bits_in_use_ff, bits_in_use_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               in_range_ff, in_range_in;
   logic               first_ff, first_in;
   logic [9:0]         chk_byte_ff, chk_byte_in;
   logic [7:0]         rd_data_ff;

   logic [12:0]        limit;
   logic               out_free;
   logic               mem_re, mem_we;
   logic [AW-1:0]      mem_raddr, mem_waddr;
   logic [7:0]         mem_wdata;
   logic [7:0]         bit_mask;
   logic [7:0]         new_byte;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bba_byte_match u_match (
      .rd_byte   (rd_data_ff),
      .byte_idx  (chk_byte_ff),
      .status    (req_ff.status),
      .first     (first_ff),
      .start_bit (req_ff.position[2:0]),
      .limit     (limit),
      .match     (match)
   );

   always_comb begin
      limit     = (32'(bits_in_use_ff) > MAX_BITS) ? MAX_LIMIT : bits_in_use_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      bit_mask  = 8'd1 << req_ff.position[2:0];
      new_byte  = req_ff.status ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);

      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      bits_in_use_in = (csr_valid && csr_ready) ? csr_data : bits_in_use_ff;
      clr_addr_in    = clr_addr_ff;
      in_range_in    = in_range_ff;
      first_in       = first_ff;
      chk_byte_in    = chk_byte_ff;
      req_ready      = 1'b0;
      mem_re         = 1'b0;
      mem_raddr      = AW'(req_data.position[11:3]);
      mem_we         = 1'b0;
      mem_waddr      = clr_addr_ff;
      mem_wdata      = 8'd0;

      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_re      = 1'b1;
               req_in      = req_data;
               in_range_in = ({1'b0, req_data.position} < limit);
               first_in    = 1'b1;
               chk_byte_in = {1'b0, req_data.position[11:3]};
               if ((req_data.mode == bba_pkg::MODE_SEARCH) &&
                   ({1'b0, req_data.position} < limit)) begin
                  state_in = bba_pkg::ST_SCAN;
               end else begin
                  state_in = bba_pkg::ST_ACCESS;
               end
            end
         end
         bba_pkg::ST_ACCESS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.error = 1'b1;
               state_in     = bba_pkg::ST_IDLE;
               if (in_range_ff && (req_ff.mode == bba_pkg::MODE_READ)) begin
                  rsp_in.error     = 1'b0;
                  rsp_in.bit_value = rd_data_ff[req_ff.position[2:0]];
               end
               if (in_range_ff && (req_ff.mode == bba_pkg::MODE_WRITE)) begin
                  rsp_in.error      = 1'b0;
                  rsp_in.byte_value = new_byte;
                  mem_we            = 1'b1;
                  mem_waddr         = AW'(req_ff.position[11:3]);
                  mem_wdata         = new_byte;
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            if (match.hit || match.last) begin
               // hold the byte in view until the result register frees up
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.error       = !match.hit;
                  rsp_in.found_index = match.hit ? {chk_byte_ff[8:0], match.bit_idx} : 12'd0;
                  state_in           = bba_pkg::ST_IDLE;
               end
            end else begin
               // advance to the next byte
               mem_re      = 1'b1;
               mem_raddr   = AW'(chk_byte_ff + 10'd1);
               chk_byte_in = chk_byte_ff + 10'd1;
               first_in    = 1'b0;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bba_pkg::ST_CLEAR;
         rsp_valid_ff   <= 1'b0;
         bits_in_use_ff <= bba_pkg::BITS_IN_USE_RESET;
         clr_addr_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         bits_in_use_ff <= bits_in_use_in;
         clr_addr_ff    <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      in_range_ff <= in_range_in;
      first_ff    <= first_in;
      chk_byte_ff <= chk_byte_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

/* tb/sv/block_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for block_bitmap_allocator: directed and random bitmap requests
// checked against a shadow copy of the bitmap. Depends on rtl/bba_pkg.sv and the RTL.

module block_bitmap_allocator_tb;

   localparam int         MAP_BITS      = 4096;
   localparam int         MAP_BYTES     = (MAP_BITS + 7) / 8;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT   = 3000000;
   localparam int         DRAIN_CYCLES  = 600;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         RANDOM_GROUPS = 6;
   localparam int         GROUP_ITEMS   = 185;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bba_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bba_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [12:0]      csr_data  = '0;

   block_bitmap_allocator #(.MAX_BITS(MAP_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   logic [7:0]       shadow_map [MAP_BYTES];
   logic [12:0]      shadow_bits_in_use = bba_pkg::BITS_IN_USE_RESET;
   bba_pkg::req_type pending_requests [$];
   bba_pkg::rsp_type predicted_results [$];
   int               queued_count   = 0;
   int               accepted_count = 0;
   int               fault_count    = 0;
   int               cycle_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_left      = 0;
   logic             hold_go        = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one request to the shadow bitmap and return the result it should produce.
   function automatic bba_pkg::rsp_type predict_bitmap_result(input bba_pkg::req_type r);
      bba_pkg::rsp_type res;
      int               lim;
      logic [7:0]       b;
      res       = '0;
      res.error = 1'b1;
      lim = (shadow_bits_in_use > MAP_BITS) ? MAP_BITS : int'(shadow_bits_in_use);
      case (r.mode)
         bba_pkg::MODE_READ: begin
            if (r.position < lim) begin
               res.error     = 1'b0;
               res.bit_value = shadow_map[r.position[11:3]][r.position[2:0]];
            end
         end
         bba_pkg::MODE_WRITE: begin
            if (r.position < lim) begin
               b                     = shadow_map[r.position[11:3]];
               b[r.position[2:0]]    = r.status;
               shadow_map[r.position[11:3]] = b;
               res.error             = 1'b0;
               res.byte_value        = b;
            end
         end
         bba_pkg::MODE_SEARCH: begin
            for (int p = r.position; p < lim; p++) begin
               if (shadow_map[p >> 3][p % 8] == r.status) begin
                  res.error       = 1'b0;
                  res.found_index = 12'(p);
                  break;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic string rsp_text(input bba_pkg::rsp_type r);
      return $sformatf("error=%0b found_index=%0d bit_value=%0b byte_value=0x%02h",
                       r.error, r.found_index, r.bit_value, r.byte_value);
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch %0d at cycle %0d: %s", fault_count, cycle_count, msg);
   endtask

   task automatic push_request(input logic [1:0] mode, input logic [11:0] pos,
                               input logic status);
      bba_pkg::req_type item;
      item.mode     = mode;
      item.position = pos;
      item.status   = status;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   // Most positions fall in a hot window so searches meet bits that earlier writes set.
   task automatic queue_random_request(input int base, input int lim);
      int          pick;
      logic [1:0]  mode;
      logic [11:0] pos;
      logic        status;
      pick = $urandom_range(99);
      mode = (pick < 30) ? bba_pkg::MODE_READ : (pick < 62) ? bba_pkg::MODE_WRITE :
             (pick < 95) ? bba_pkg::MODE_SEARCH : MODE_UNUSED;
      pick = $urandom_range(99);
      if (pick < 65)
         pos = 12'(base + $urandom_range(255));
      else if (pick < 70)
         pos = 12'(lim - $urandom_range(1));
      else
         pos = 12'($urandom_range(4095));
      if (mode == bba_pkg::MODE_WRITE)
         status = ($urandom_range(99) < 65);
      else
         status = 1'($urandom_range(1));
      push_request(mode, pos, status);
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bits_in_use(input logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_bits_in_use = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: hold the payload until accepted, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(predict_bitmap_result(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure.
   always @(posedge clock) begin : result_monitor
      bba_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_fault($sformatf("result with none pending: %s", rsp_text(rsp_data)));
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.error !== want.error ||
                   rsp_data.found_index !== want.found_index ||
                   rsp_data.bit_value !== want.bit_value ||
                   rsp_data.byte_value !== want.byte_value)
                  report_fault($sformatf("expected %s, got %s",
                                         rsp_text(want), rsp_text(rsp_data)));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      logic [12:0] group_cfg [RANDOM_GROUPS];
      int          lim;
      int          base;
      for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = '0;
      group_cfg = '{13'd8191, 13'd1000, 13'd4096, 13'd64, 13'd4095, 13'd2500};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Full-size map: corners, set and clear within one byte, searches both ways.
      push_request(bba_pkg::MODE_READ,   12'd0,    1'b0);
      push_request(bba_pkg::MODE_READ,   12'd4095, 1'b1);
      push_request(bba_pkg::MODE_WRITE,  12'd4095, 1'b1);
      push_request(bba_pkg::MODE_WRITE,  12'd0,    1'b1);
      push_request(bba_pkg::MODE_WRITE,  12'd7,    1'b1);
      push_request(bba_pkg::MODE_WRITE,  12'd7,    1'b0);
      push_request(bba_pkg::MODE_READ,   12'd0,    1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd0,    1'b1);
      push_request(bba_pkg::MODE_SEARCH, 12'd1,    1'b1);
      push_request(bba_pkg::MODE_SEARCH, 12'd0,    1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd4095, 1'b0);
      push_request(MODE_UNUSED,          12'd5,    1'b1);
      wait_idle();

      // Last bit out of range; search starting at the count.
      write_bits_in_use(13'd4095);
      push_request(bba_pkg::MODE_READ,   12'd4095, 1'b0);
      push_request(bba_pkg::MODE_WRITE,  12'd4095, 1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd4095, 1'b1);
      push_request(bba_pkg::MODE_SEARCH, 12'd4094, 1'b1);
      wait_idle();

      // Empty map: everything is out of range.
      write_bits_in_use(13'd0);
      push_request(bba_pkg::MODE_READ,   12'd0, 1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd0, 1'b0);
      wait_idle();

      // Oversized count clamps to the full map.
      write_bits_in_use(13'd8191);
      push_request(bba_pkg::MODE_READ,   12'd4095, 1'b0);
      push_request(bba_pkg::MODE_WRITE,  12'd4095, 1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd2000, 1'b1);
      wait_idle();

      write_bits_in_use(13'd1);
      push_request(bba_pkg::MODE_WRITE,  12'd0, 1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd0, 1'b0);
      push_request(bba_pkg::MODE_SEARCH, 12'd0, 1'b1);
      wait_idle();

      for (int g = 0; g < RANDOM_GROUPS; g++) begin
         if (g == 0) begin
            send_idle_pct  = 22;
            recv_stall_pct = 72;
         end else if (g == 2) begin
            send_idle_pct  = 72;
            recv_stall_pct = 22;
         end else if (g == 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_bits_in_use(group_cfg[g]);
         lim  = (group_cfg[g] > MAP_BITS) ? MAP_BITS : int'(group_cfg[g]);
         base = (lim > 256) ? $urandom_range(lim - 256) : 0;
         for (int n = 0; n < GROUP_ITEMS; n++) queue_random_request(base, lim);
         if (g == 4) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (predicted_results.size() != 0)
         report_fault($sformatf("%0d results never arrived", predicted_results.size()));
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/bba_pkg.sv
rtl/bba_byte_match.sv
rtl/block_bitmap_allocator.sv
tb/sv/block_bitmap_allocator_tb.sv
